// ----- rtl/heisenberg_hamiltonian_column_gen_defines.svh -----
// ----------------------------------------------------------------------------
// Heisenberg column generator assertion macros
// Shared property wrappers for the bound checker.
// ----------------------------------------------------------------------------
`ifndef HEISENBERG_HAMILTONIAN_COLUMN_GEN_DEFINES_SVH
`define HEISENBERG_HAMILTONIAN_COLUMN_GEN_DEFINES_SVH

// same-cycle implication
`define HHCG_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define HHCG_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/hhcg_pkg.sv -----
// ----------------------------------------------------------------------------
// hhcg_pkg
// Widths, register indices, reset values and control structs shared by the
// Heisenberg column generator.
// ----------------------------------------------------------------------------
package hhcg_pkg;

   localparam int DEF_MAX_ROWS = 4;
   localparam int DEF_MAX_COLS = 4;

   localparam int STATE_W    = 16;
   localparam int VALUE_W    = 21;
   localparam int J_W        = 16;
   localparam int DIM_W      = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // at most one diagonal plus this many off-diagonal entries per request
   localparam int MAX_FLIPS  = 24;
   localparam int FLIP_CNT_W = 5;

   localparam int VAL_MAX = 1048575;
   localparam int VAL_MIN = -1048576;

   localparam logic [CSR_IDX_W-1:0] REG_ROWS     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_COLS     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_COUPLING = 2'd2;

   localparam logic [DIM_W-1:0]      RST_ROWS     = 3'd2;
   localparam logic [DIM_W-1:0]      RST_COLS     = 3'd2;
   localparam logic signed [J_W-1:0] RST_COUPLING = 16'sd4096;

   typedef struct packed {
      logic load;
      logic scan_step;
      logic emit_diag;
      logic flip_step;
   } dp_cmd_type;

   typedef struct packed {
      logic last_site;
      logic cur_anti;
      logic last_flip;
      logic no_flips;
      logic walk_end;
   } dp_stat_type;

endpackage

// ----- rtl/heisenberg_hamiltonian_column_gen.sv -----
// ----------------------------------------------------------------------------
// heisenberg_hamiltonian_column_gen
// Emits the nonzero column of the square-lattice Heisenberg Hamiltonian for
// one basis state: the diagonal entry first, then one 2J entry per
// anti-aligned bond in row-major order, horizontal bond before vertical.
//
//   channel   ports                                         flow
//   request   start, busy, req_basis_state                  start while !busy
//   response  rsp_valid, rsp_target_state,                  one-cycle strobe
//             rsp_element_value, rsp_last_entry
//   config    csr_valid, csr_ready, csr_index, csr_wdata    valid & ready
//
// For a request with S = rows*cols sites, the scan pass visits one site per
// cycle to build the diagonal, which is then emitted; the flip pass then walks
// up to 2*S bond slots, one per cycle, and stops at the last flip entry.
// busy stays high until the final result is in the output register.
// Synchronous reset restores a 2x2 lattice with J = 1.0.
// Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module heisenberg_hamiltonian_column_gen #(
   parameter int MAX_ROWS = hhcg_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS = hhcg_pkg::DEF_MAX_COLS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [hhcg_pkg::STATE_W-1:0]        req_basis_state,
   output logic                                rsp_valid,
   output logic [hhcg_pkg::STATE_W-1:0]        rsp_target_state,
   output logic signed [hhcg_pkg::VALUE_W-1:0] rsp_element_value,
   output logic                                rsp_last_entry,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [hhcg_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [hhcg_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import hhcg_pkg::*;

   logic [DIM_W-1:0]      lattice_rows;
   logic [DIM_W-1:0]      lattice_cols;
   logic signed [J_W-1:0] coupling_j;
   dp_cmd_type            cmd;
   dp_stat_type           stat;

   hhcg_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .lattice_rows (lattice_rows),
      .lattice_cols (lattice_cols),
      .coupling_j   (coupling_j)
   );

   hhcg_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   hhcg_dp #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .basis_state       (req_basis_state),
      .lattice_rows      (lattice_rows),
      .lattice_cols      (lattice_cols),
      .coupling_j        (coupling_j),
      .rsp_valid         (rsp_valid),
      .rsp_target_state  (rsp_target_state),
      .rsp_element_value (rsp_element_value),
      .rsp_last_entry    (rsp_last_entry)
   );

endmodule

// ----- rtl/hhcg_csr.sv -----
// ----------------------------------------------------------------------------
// hhcg_csr
// Configuration registers: lattice size and exchange coupling.
// ----------------------------------------------------------------------------
module hhcg_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [hhcg_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [hhcg_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output logic [hhcg_pkg::DIM_W-1:0]          lattice_rows,
   output logic [hhcg_pkg::DIM_W-1:0]          lattice_cols,
   output logic signed [hhcg_pkg::J_W-1:0]     coupling_j
);
   import hhcg_pkg::*;

   logic [DIM_W-1:0]      rows_ff;
   logic [DIM_W-1:0]      cols_ff;
   logic signed [J_W-1:0] coupling_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff     <= RST_ROWS;
         cols_ff     <= RST_COLS;
         coupling_ff <= RST_COUPLING;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_ROWS:     rows_ff     <= csr_wdata[DIM_W-1:0];
            REG_COLS:     cols_ff     <= csr_wdata[DIM_W-1:0];
            REG_COUPLING: coupling_ff <= csr_wdata[J_W-1:0];
            default: ;
         endcase
      end
   end

   assign lattice_rows = rows_ff;
   assign lattice_cols = cols_ff;
   assign coupling_j   = coupling_ff;

endmodule

// ----- rtl/hhcg_ctrl.sv -----
// ----------------------------------------------------------------------------
// hhcg_ctrl
// Sequencer: scan pass for the diagonal, diagonal emit, then flip pass.
// ----------------------------------------------------------------------------
module hhcg_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  hhcg_pkg::dp_stat_type    stat,
   output hhcg_pkg::dp_cmd_type     cmd
);
   import hhcg_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_SCAN = 4'b0010,
      S_DIAG = 4'b0100,
      S_FLIP = 4'b1000
   } ctrl_state_type;

   ctrl_state_type fsm_ff;
   ctrl_state_type fsm_in;

   always_comb begin
      fsm_in = fsm_ff;
      cmd    = '0;
      unique case (fsm_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               fsm_in   = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.last_site) fsm_in = S_DIAG;
         end
         S_DIAG: begin
            cmd.emit_diag = 1'b1;
            fsm_in        = stat.no_flips ? S_IDLE : S_FLIP;
         end
         S_FLIP: begin
            cmd.flip_step = 1'b1;
            if ((stat.cur_anti && stat.last_flip) || stat.walk_end) fsm_in = S_IDLE;
         end
         default: fsm_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) fsm_ff <= S_IDLE;
      else       fsm_ff <= fsm_in;
   end

   assign busy = (fsm_ff != S_IDLE);

endmodule

// ----- rtl/hhcg_dp.sv -----
// ----------------------------------------------------------------------------
// hhcg_dp
// Bond walker, diagonal accumulator, flip counter and result register.
// ----------------------------------------------------------------------------
module hhcg_dp #(
   parameter int MAX_ROWS = hhcg_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS = hhcg_pkg::DEF_MAX_COLS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  hhcg_pkg::dp_cmd_type                cmd,
   output hhcg_pkg::dp_stat_type               stat,
   input  logic [hhcg_pkg::STATE_W-1:0]        basis_state,
   input  logic [hhcg_pkg::DIM_W-1:0]          lattice_rows,
   input  logic [hhcg_pkg::DIM_W-1:0]          lattice_cols,
   input  logic signed [hhcg_pkg::J_W-1:0]     coupling_j,
   output logic                                rsp_valid,
   output logic [hhcg_pkg::STATE_W-1:0]        rsp_target_state,
   output logic signed [hhcg_pkg::VALUE_W-1:0] rsp_element_value,
   output logic                                rsp_last_entry
);
   import hhcg_pkg::*;

   localparam int MAX_SITES = MAX_ROWS * MAX_COLS;
   localparam int RW        = $clog2(MAX_ROWS + 1);
   localparam int CW        = $clog2(MAX_COLS + 1);
   localparam int SW        = $clog2(MAX_SITES + 1);
   localparam int AW_RAW    = J_W + 2 + SW;
   localparam int AW        = (AW_RAW > VALUE_W + 1) ? AW_RAW : VALUE_W + 1;

   localparam logic signed [AW-1:0] ACC_MAX = AW'(VAL_MAX);
   localparam logic signed [AW-1:0] ACC_MIN = AW'(VAL_MIN);
   localparam logic [STATE_W-1:0]   BIT0    = STATE_W'(1);

   // effective lattice size, clamped into 1..MAX
   logic [RW-1:0] rows_eff;
   logic [CW-1:0] cols_eff;
   logic [SW-1:0] sites_in;
   logic [STATE_W-1:0] site_mask;

   logic [RW-1:0]     rows_ff;
   logic [CW-1:0]     cols_ff;
   logic [SW-1:0]     sites_ff;
   logic [STATE_W-1:0] st_ff;
   logic [RW-1:0]     r_ff;
   logic [CW-1:0]     c_ff;
   logic [SW-1:0]     idx_ff;
   logic              dir_ff;
   logic signed [AW-1:0] acc_ff;
   logic [FLIP_CNT_W-1:0] nflip_ff;
   logic [FLIP_CNT_W-1:0] sent_ff;

   logic                  rsp_valid_ff;
   logic [STATE_W-1:0]    rsp_state_ff;
   logic signed [VALUE_W-1:0] rsp_value_ff;
   logic                  rsp_last_ff;

   logic [SW-1:0]      pos_a, pos_bh, pos_bv, pos_b;
   logic [STATE_W-1:0] sh_a, sh_bh, sh_bv;
   logic               h_ok, v_ok, h_anti, v_anti, cur_anti;
   logic signed [AW-1:0] jx, term_h, term_v, acc_sum;
   logic [FLIP_CNT_W:0]   nsum;
   logic [FLIP_CNT_W-1:0] nflip_in;
   logic [STATE_W-1:0]    flip_state;
   logic signed [VALUE_W-1:0] diag_sat, two_j;
   logic                  row_end;

   always_comb begin
      if (lattice_rows == '0)              rows_eff = RW'(1);
      else if (int'(lattice_rows) > MAX_ROWS) rows_eff = RW'(MAX_ROWS);
      else                                 rows_eff = RW'(lattice_rows);
      if (lattice_cols == '0)              cols_eff = CW'(1);
      else if (int'(lattice_cols) > MAX_COLS) cols_eff = CW'(MAX_COLS);
      else                                 cols_eff = CW'(lattice_cols);
      sites_in = SW'(rows_eff) * SW'(cols_eff);
      for (int i = 0; i < STATE_W; i++) site_mask[i] = (i < int'(sites_in));
   end

   // site (r,c) sits at bit sites-1-idx; right neighbour one below, lower one cols below
   always_comb begin
      pos_a  = sites_ff - idx_ff - SW'(1);
      pos_bh = pos_a - SW'(1);
      pos_bv = pos_a - SW'(cols_ff);
      sh_a   = st_ff >> pos_a;
      sh_bh  = st_ff >> pos_bh;
      sh_bv  = st_ff >> pos_bv;
      h_ok   = (c_ff + CW'(1)) < cols_ff;
      v_ok   = (r_ff + RW'(1)) < rows_ff;
      h_anti = h_ok & (sh_a[0] ^ sh_bh[0]);
      v_anti = v_ok & (sh_a[0] ^ sh_bv[0]);
      cur_anti = dir_ff ? v_anti : h_anti;
      pos_b    = dir_ff ? pos_bv : pos_bh;
      flip_state = st_ff ^ (BIT0 << pos_a) ^ (BIT0 << pos_b);
      row_end  = (c_ff + CW'(1)) == cols_ff;

      jx     = {{(AW-J_W){coupling_j[J_W-1]}}, coupling_j};
      term_h = !h_ok ? '0 : (h_anti ? -jx : jx);
      term_v = !v_ok ? '0 : (v_anti ? -jx : jx);
      acc_sum = acc_ff + term_h + term_v;

      nsum = {1'b0, nflip_ff} + (FLIP_CNT_W+1)'(h_anti) + (FLIP_CNT_W+1)'(v_anti);
      nflip_in = (int'(nsum) > MAX_FLIPS) ? FLIP_CNT_W'(MAX_FLIPS) : nsum[FLIP_CNT_W-1:0];

      if (acc_ff > ACC_MAX)      diag_sat = ACC_MAX[VALUE_W-1:0];
      else if (acc_ff < ACC_MIN) diag_sat = ACC_MIN[VALUE_W-1:0];
      else                       diag_sat = acc_ff[VALUE_W-1:0];
      two_j = {{(VALUE_W-J_W-1){coupling_j[J_W-1]}}, coupling_j, 1'b0};
   end

   always_comb begin
      stat.last_site = (idx_ff == sites_ff - SW'(1));
      stat.cur_anti  = cur_anti;
      stat.last_flip = (sent_ff + FLIP_CNT_W'(1)) == nflip_ff;
      stat.no_flips  = (nflip_ff == '0);
      stat.walk_end  = stat.last_site & dir_ff;
   end

   // walker and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         r_ff     <= '0;
         c_ff     <= '0;
         idx_ff   <= '0;
         dir_ff   <= 1'b0;
         nflip_ff <= '0;
         sent_ff  <= '0;
      end else if (cmd.load) begin
         r_ff     <= '0;
         c_ff     <= '0;
         idx_ff   <= '0;
         dir_ff   <= 1'b0;
         nflip_ff <= '0;
         sent_ff  <= '0;
      end else if (cmd.scan_step) begin
         nflip_ff <= nflip_in;
         idx_ff   <= idx_ff + SW'(1);
         if (row_end) begin
            c_ff <= '0;
            r_ff <= r_ff + RW'(1);
         end else begin
            c_ff <= c_ff + CW'(1);
         end
      end else if (cmd.emit_diag) begin
         r_ff    <= '0;
         c_ff    <= '0;
         idx_ff  <= '0;
         dir_ff  <= 1'b0;
         sent_ff <= '0;
      end else if (cmd.flip_step) begin
         if (cur_anti) sent_ff <= sent_ff + FLIP_CNT_W'(1);
         dir_ff <= ~dir_ff;
         if (dir_ff) begin
            idx_ff <= idx_ff + SW'(1);
            if (row_end) begin
               c_ff <= '0;
               r_ff <= r_ff + RW'(1);
            end else begin
               c_ff <= c_ff + CW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rows_ff  <= rows_eff;
         cols_ff  <= cols_eff;
         sites_ff <= sites_in;
         st_ff    <= basis_state & site_mask;
         acc_ff   <= '0;
      end else if (cmd.scan_step) begin
         acc_ff <= acc_sum;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= cmd.emit_diag | (cmd.flip_step & cur_anti);
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_diag) begin
         rsp_state_ff <= st_ff;
         rsp_value_ff <= diag_sat;
         rsp_last_ff  <= stat.no_flips;
      end else if (cmd.flip_step && cur_anti) begin
         rsp_state_ff <= flip_state;
         rsp_value_ff <= two_j;
         rsp_last_ff  <= stat.last_flip;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_target_state  = rsp_state_ff;
   assign rsp_element_value = rsp_value_ff;
   assign rsp_last_entry    = rsp_last_ff;

endmodule

// ----- rtl/hhcg_checker.sv -----
// ----------------------------------------------------------------------------
// hhcg_checker
// Port-level temporal checks for the column generator, bound to the top.
// ----------------------------------------------------------------------------
`include "heisenberg_hamiltonian_column_gen_defines.svh"

module hhcg_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input logic rsp_last_entry,
   input logic csr_valid,
   input logic csr_ready
);

   `HHCG_ASSERT_NXT(a_accept_busy, clock, reset, start && !busy, busy, "busy not raised after request")

   `HHCG_ASSERT_NXT(a_accept_quiet, clock, reset, start && !busy, !rsp_valid, "result straight after request")

   `HHCG_ASSERT_NXT(a_last_gap, clock, reset, rsp_valid && rsp_last_entry, !rsp_valid, "result after last entry")

   `HHCG_ASSERT_IMP(a_more_busy, clock, reset, rsp_valid && !rsp_last_entry, busy, "idle with entries pending")

   `HHCG_ASSERT_IMP(a_csr_ready, clock, reset, csr_valid, csr_ready, "config write refused")

endmodule

bind heisenberg_hamiltonian_column_gen hhcg_checker u_hhcg_checker (.*);

// ----- tb/tb_heisenberg_hamiltonian_column_gen.sv -----
// ----------------------------------------------------------------------------
// tb_heisenberg_hamiltonian_column_gen
// Self-checking bench for the Heisenberg column generator. Basis states are
// sent over the start/busy request port under a range of lattice shapes and
// couplings. Each accepted request is expanded into its expected column
// (diagonal first, then one 2J entry per anti-aligned bond). Every strobed
// result is checked against the oldest outstanding entry.
// ----------------------------------------------------------------------------
module tb_heisenberg_hamiltonian_column_gen;
   import hhcg_pkg::*;

   localparam int PERIOD          = 10;
   localparam int ITEMS_PER_PHASE = 25;
   localparam int RANDOM_PHASES   = 8;
   localparam int DRAIN_CYCLES    = 50;

   // index 3 decodes to nothing; written anyway to show it is ignored
   localparam logic [CSR_IDX_W-1:0] REG_SPARE = 2'd3;

   typedef struct packed {
      logic [STATE_W-1:0]        target;
      logic signed [VALUE_W-1:0] value;
      logic                      last;
   } column_entry_type;

   class column_scoreboard_type;
      logic [DIM_W-1:0]      rows;
      logic [DIM_W-1:0]      cols;
      logic signed [J_W-1:0] coupling;
      column_entry_type      entries[$];
      int                    errors;

      function new();
         rows     = RST_ROWS;
         cols     = RST_COLS;
         coupling = RST_COUPLING;
         errors   = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            REG_ROWS:     rows = data[DIM_W-1:0];
            REG_COLS:     cols = data[DIM_W-1:0];
            REG_COUPLING: coupling = data[J_W-1:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return entries.size();
      endfunction

      function logic signed [VALUE_W-1:0] clip_value(int v);
         if (v > VAL_MAX) return VALUE_W'(VAL_MAX);
         if (v < VAL_MIN) return VALUE_W'(VAL_MIN);
         return VALUE_W'(v);
      endfunction

      function logic [STATE_W-1:0] site_bit(int unsigned sites, int unsigned idx);
         return STATE_W'(1) << (sites - 1 - idx);
      endfunction

      // expands one basis state into its Hamiltonian column
      function void note_request(logic [STATE_W-1:0] basis);
         int unsigned        nr, nc, sites, r, c, d;
         int                 diag;
         logic [STATE_W-1:0] st, ma, mb;
         logic [STATE_W-1:0] flips[$];
         nr = (rows == 0) ? 1 : ((rows > DEF_MAX_ROWS) ? DEF_MAX_ROWS : rows);
         nc = (cols == 0) ? 1 : ((cols > DEF_MAX_COLS) ? DEF_MAX_COLS : cols);
         sites = nr * nc;
         st = basis & STATE_W'((32'd1 << sites) - 1);
         diag = 0;
         for (r = 0; r < nr; r++) begin
            for (c = 0; c < nc; c++) begin
               for (d = 0; d < 2; d++) begin
                  if (d == 0 && c + 1 >= nc) continue;
                  if (d == 1 && r + 1 >= nr) continue;
                  ma = site_bit(sites, r * nc + c);
                  mb = site_bit(sites, (d == 0) ? r * nc + c + 1 : (r + 1) * nc + c);
                  if (((st & ma) != 0) == ((st & mb) != 0)) begin
                     diag += coupling;
                  end else begin
                     diag -= coupling;
                     if (flips.size() < MAX_FLIPS) flips.insert(flips.size(), st ^ ma ^ mb);
                  end
               end
            end
         end
         entries.insert(entries.size(),
                        column_entry_type'{st, clip_value(diag), flips.size() == 0});
         foreach (flips[k])
            entries.insert(entries.size(),
                           column_entry_type'{flips[k], clip_value(2 * coupling),
                                              k == flips.size() - 1});
      endfunction

      task report_mismatch(string msg);
         $display("MISMATCH @%0t: %s", $realtime, msg);
         errors++;
      endtask

      task check_entry(logic [STATE_W-1:0] target, logic signed [VALUE_W-1:0] value,
                       logic last);
         column_entry_type want;
         if (entries.size() == 0) begin
            report_mismatch($sformatf("result %h/%0d/%0b with nothing outstanding",
                                      target, value, last));
            return;
         end
         want = entries.pop_front();
         if (target !== want.target)
            report_mismatch($sformatf("target_state %h, wanted %h", target, want.target));
         if (value !== want.value)
            report_mismatch($sformatf("element_value %0d, wanted %0d", value, want.value));
         if (last !== want.last)
            report_mismatch($sformatf("last_entry %b, wanted %b (target %h)",
                                      last, want.last, want.target));
      endtask
   endclass

   logic                        clock;
   logic                        reset = 1'b1;
   logic                        start = 1'b0;
   logic                        busy;
   logic [STATE_W-1:0]          req_basis_state = '0;
   logic                        rsp_valid;
   logic [STATE_W-1:0]          rsp_target_state;
   logic signed [VALUE_W-1:0]   rsp_element_value;
   logic                        rsp_last_entry;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic [CSR_IDX_W-1:0]        csr_index = '0;
   logic [CSR_DATA_W-1:0]       csr_wdata = '0;

   column_scoreboard_type column_model;

   heisenberg_hamiltonian_column_gen dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_basis_state   (req_basis_state),
      .rsp_valid         (rsp_valid),
      .rsp_target_state  (rsp_target_state),
      .rsp_element_value (rsp_element_value),
      .rsp_last_entry    (rsp_last_entry),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #(PERIOD / 2) clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         column_model.check_entry(rsp_target_state, rsp_element_value, rsp_last_entry);
   end

   // start is left high so a back-to-back request is taken as soon as the block is idle
   task automatic send_state(input logic [STATE_W-1:0] basis);
      start           <= 1'b1;
      req_basis_state <= basis;
      do @(posedge clock); while (busy);
      column_model.note_request(basis);
   endtask

   task automatic pause_sender(input bit calm);
      int unsigned n;
      if (calm || $urandom_range(0, 2) != 0) return;
      start <= 1'b0;
      // sometimes let the block go idle first so the gap lands outside a column
      if ($urandom_range(0, 1) == 1) begin
         do @(posedge clock); while (busy);
      end
      n = $urandom_range(1, 3);
      repeat (n) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      column_model.write_reg(idx, data);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (column_model.pending() != 0 || busy) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // registers only change with the block idle; upper data bits are noise
   task automatic set_lattice(input logic [DIM_W-1:0] nr, input logic [DIM_W-1:0] nc,
                              input logic signed [J_W-1:0] j);
      wait_drained();
      write_csr(REG_ROWS, {13'($urandom), nr});
      write_csr(REG_COLS, {13'($urandom), nc});
      write_csr(REG_COUPLING, j);
      if ($urandom_range(0, 1) == 1) write_csr(REG_SPARE, CSR_DATA_W'($urandom));
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic signed [J_W-1:0] j_pick;
      logic [STATE_W-1:0]    basis_pick;
      column_model = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset lattice 2x2, J = 1.0; upper bits must be masked off
      send_state(16'h0000); pause_sender(1'b0);
      send_state(16'hFFFF); pause_sender(1'b0);
      send_state(16'h0009); pause_sender(1'b0);
      send_state(16'hFFF6); pause_sender(1'b0);

      // full 4x4, checkerboards hit every bond anti-aligned
      set_lattice(3'd4, 3'd4, 16'sh7FFF);
      send_state(16'hA5A5); pause_sender(1'b0);
      send_state(16'h5A5A); pause_sender(1'b0);
      send_state(16'h0000); pause_sender(1'b0);
      send_state(16'h8001); pause_sender(1'b0);

      set_lattice(3'd4, 3'd4, 16'sh8000);
      send_state(16'hA5A5); pause_sender(1'b0);
      send_state(16'hFFFF); pause_sender(1'b0);
      send_state(16'h1234); pause_sender(1'b0);

      // zero dimensions read as 1: single site, no bonds
      set_lattice(3'd0, 3'd0, 16'sh0000);
      send_state(16'hFFFF); pause_sender(1'b0);
      send_state(16'h0001); pause_sender(1'b0);

      // oversize rows saturate to a 4x1 column
      set_lattice(3'd7, 3'd1, -16'sd1);
      send_state(16'h000A); pause_sender(1'b0);
      send_state(16'h0005); pause_sender(1'b0);
      send_state(16'hFFFF); pause_sender(1'b0);

      set_lattice(3'd1, 3'd7, 16'sh0000);
      send_state(16'h0005); pause_sender(1'b0);
      send_state(16'hFFFA); pause_sender(1'b0);

      set_lattice(3'd3, 3'd5, 16'sd12345);
      send_state(16'hFFFF); pause_sender(1'b0);
      send_state(16'h0AAA); pause_sender(1'b0);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case ($urandom_range(0, 5))
            0:       j_pick = 16'sh8000;
            1:       j_pick = 16'sh7FFF;
            2:       j_pick = '0;
            default: j_pick = J_W'($urandom);
         endcase
         set_lattice(DIM_W'($urandom_range(0, 7)), DIM_W'($urandom_range(0, 7)), j_pick);
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            basis_pick = STATE_W'($urandom);
            if ($urandom_range(0, 7) == 0)
               basis_pick = 16'hA5A5 ^ (STATE_W'(1) << $urandom_range(0, 15));
            send_state(basis_pick);
            // no idling over the closing stretch
            pause_sender(p >= RANDOM_PHASES - 2);
         end
      end

      start <= 1'b0;
      while (column_model.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (column_model.errors == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #(PERIOD * 200000);
      $display("TIMEOUT: results still outstanding");
      $display("end of test: mismatches");
      $finish;
   end

endmodule

// ----- heisenberg_hamiltonian_column_gen.f -----
+incdir+rtl
rtl/hhcg_pkg.sv
rtl/hhcg_csr.sv
rtl/hhcg_ctrl.sv
rtl/hhcg_dp.sv
rtl/heisenberg_hamiltonian_column_gen.sv
rtl/hhcg_checker.sv
tb/tb_heisenberg_hamiltonian_column_gen.sv
